// ----- sv/hmb_pkg.sv -----
// ----------------------------------------------------------------------------
// hmb_pkg: shared types and constants of the heightmap mesh builder
// Word layouts, request codes, status codes and the handshake structs
// that run between the controller, the divider and the normalizer.
// ----------------------------------------------------------------------------
package hmb_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int SIDE_W     = 9;
    localparam int CELLS      = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int TRI_W      = ADDR_W + 2;
    localparam int DIV_CNT_W  = $clog2(ADDR_W);
    localparam int SUM_W      = 20;
    localparam int NRM_W      = 16;
    localparam int UNIT       = 16384;
    localparam int RESET_NTRI = 2 * (MAX_SIDE - 1) * (MAX_SIDE - 1);

    // request kinds
    localparam logic [1:0] K_LOAD = 2'd0;
    localparam logic [1:0] K_VERT = 2'd1;
    localparam logic [1:0] K_TRI  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_BUILT  = 2'd1;
    localparam logic [1:0] ST_OK     = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [15:0] height;
        logic        [15:0] plate_id;
        logic        [16:0] address;
    } t_in_word;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic        [15:0] plate_out;
        logic        [15:0] index_a;
        logic        [15:0] index_b;
        logic        [15:0] index_c;
    } t_out_word;

    // one entry of the normal-sum memory, also the normalizer input
    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_nrm;

    typedef struct packed {
        logic start;
        t_vec vec;
    } t_nrm_req;

    typedef struct packed {
        logic done;
        t_nrm nrm;
    } t_nrm_rsp;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [SIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quo;
        logic [SIDE_W-1:0] rem;
    } t_div_rsp;

endpackage

// ----- sv/heightmap_mesh_builder.sv -----
// ----------------------------------------------------------------------------
// heightmap_mesh_builder: grid mesh with vertex normals from a heightmap
// Loads height and plate samples, builds summed vertex normals, serves
// vertex and triangle reads.
// ----------------------------------------------------------------------------
// One word is taken at a time. The load that completes the grid also
// runs the build: a clearing pass over all side*side normal sums, then
// per quad 4 height reads plus, for each of its two triangles, one pass
// of the normalizer (3 square steps, 28 root steps, then a serial divide
// per component) and three read-modify-writes of the sums. A vertex read
// runs a row/column divide, a memory read and the normalizer; a triangle
// read runs the divide. Bad or early reads answer without a divide.
// The output register lets the next word enter while a result still waits.
// ----------------------------------------------------------------------------
module heightmap_mesh_builder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [hmb_pkg::SIDE_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  hmb_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output hmb_pkg::t_out_word         o_out_word
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_LOAD  = 5'd2;
    localparam logic [4:0] S_CLR   = 5'd3;
    localparam logic [4:0] S_HRD   = 5'd4;
    localparam logic [4:0] S_TNRM  = 5'd5;
    localparam logic [4:0] S_TWAIT = 5'd6;
    localparam logic [4:0] S_ARD   = 5'd7;
    localparam logic [4:0] S_AWR   = 5'd8;
    localparam logic [4:0] S_DIVW  = 5'd9;
    localparam logic [4:0] S_VRD   = 5'd10;
    localparam logic [4:0] S_VNRM  = 5'd11;
    localparam logic [4:0] S_VWAIT = 5'd12;
    localparam logic [4:0] S_TIDX  = 5'd13;
    localparam logic [4:0] S_TOUT  = 5'd14;
    localparam logic [4:0] S_PUSH  = 5'd15;

    // control
    logic [4:0]                    r_state;
    logic [hmb_pkg::SIDE_W-1:0]    r_side;
    logic [hmb_pkg::CNT_W-1:0]     r_nv;
    logic [hmb_pkg::TRI_W-1:0]     r_ntri;
    logic [hmb_pkg::CNT_W-1:0]     r_load_count;
    logic                          r_mesh_ready;
    logic                          r_out_valid;
    // working registers
    hmb_pkg::t_in_word             r_item;
    hmb_pkg::t_out_word            r_res;
    hmb_pkg::t_out_word            r_out;
    logic [hmb_pkg::ADDR_W-1:0]    r_ptr;
    logic [hmb_pkg::ADDR_W-1:0]    r_qi;
    logic [hmb_pkg::SIDE_W-1:0]    r_row;
    logic [hmb_pkg::SIDE_W-1:0]    r_col;
    logic [2:0]                    r_hstep;
    logic signed [15:0]            r_hq [4];
    logic                          r_tri;
    logic [1:0]                    r_vk;
    hmb_pkg::t_nrm                 r_tn;
    logic signed [15:0]            r_vh;
    logic [15:0]                   r_vp;
    logic [hmb_pkg::ADDR_W-1:0]    r_base;

    // memories and their registered read data
    logic [15:0]                   r_height_mem [hmb_pkg::CELLS];
    logic [15:0]                   r_plate_mem  [hmb_pkg::CELLS];
    hmb_pkg::t_vec                 r_sum_mem    [hmb_pkg::CELLS];
    logic [15:0]                   r_height_q;
    logic [15:0]                   r_plate_q;
    hmb_pkg::t_vec                 r_sum_q;

    // memory ports
    logic                          h_we;
    logic [hmb_pkg::ADDR_W-1:0]    h_raddr;
    logic                          s_we;
    logic [hmb_pkg::ADDR_W-1:0]    s_addr;
    logic [hmb_pkg::ADDR_W-1:0]    s_raddr;
    hmb_pkg::t_vec                 s_wdata;

    // configuration decode
    logic [hmb_pkg::SIDE_W-1:0]    cfg_side;
    logic [hmb_pkg::SIDE_W-1:0]    cfg_q1;
    logic [2*hmb_pkg::SIDE_W-1:0]  cfg_sq;
    logic [2*hmb_pkg::SIDE_W-1:0]  cfg_q1sq;

    // quad and triangle addressing
    logic [hmb_pkg::ADDR_W-1:0]    qv_dn;
    logic [hmb_pkg::ADDR_W-1:0]    qv_dg;
    logic [hmb_pkg::ADDR_W-1:0]    qv_rt;
    logic [hmb_pkg::ADDR_W-1:0]    tri_v;
    logic [hmb_pkg::SIDE_W-1:0]    side_m2;
    logic [hmb_pkg::CNT_W-1:0]     n_load_count;

    // vertex read fields
    logic [15:0]                   half;
    logic [hmb_pkg::ADDR_W-1:0]    b_dn;

    hmb_pkg::t_div_req             div_req;
    hmb_pkg::t_div_rsp             div_rsp;
    hmb_pkg::t_nrm_req             nrm_req;
    hmb_pkg::t_nrm_rsp             nrm_rsp;

    hmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    hmb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (nrm_req),
        .o_rsp   (nrm_rsp)
    );

    // Clamp side into its legal range and precompute the vertex and
    // triangle counts used by the address checks.
    always_comb begin
        if (i_cfg_wr_data < hmb_pkg::SIDE_W'(2)) begin
            cfg_side = hmb_pkg::SIDE_W'(2);
        end else if (i_cfg_wr_data > hmb_pkg::SIDE_W'(hmb_pkg::MAX_SIDE)) begin
            cfg_side = hmb_pkg::SIDE_W'(hmb_pkg::MAX_SIDE);
        end else begin
            cfg_side = i_cfg_wr_data;
        end
    end

    assign cfg_q1   = cfg_side - 1'b1;
    assign cfg_sq   = cfg_side * cfg_side;
    assign cfg_q1sq = cfg_q1 * cfg_q1;

    // quad corners: i, i+side, i+side+1, i+1
    assign qv_dn   = r_qi + hmb_pkg::ADDR_W'(r_side);
    assign qv_dg   = qv_dn + 1'b1;
    assign qv_rt   = r_qi + 1'b1;
    assign side_m2 = r_side - hmb_pkg::SIDE_W'(2);

    // triangle 0 is (i, dn, dg); triangle 1 is (dg, rt, i)
    always_comb begin
        case ({r_tri, r_vk})
            3'b000:  tri_v = r_qi;
            3'b001:  tri_v = qv_dn;
            3'b010:  tri_v = qv_dg;
            3'b100:  tri_v = qv_dg;
            3'b101:  tri_v = qv_rt;
            default: tri_v = r_qi;
        endcase
    end

    always_comb begin
        case (r_hstep)
            3'd0:    h_raddr = r_qi;
            3'd1:    h_raddr = qv_dn;
            3'd2:    h_raddr = qv_dg;
            3'd3:    h_raddr = qv_rt;
            default: h_raddr = r_item.address[hmb_pkg::ADDR_W-1:0];
        endcase
        if (r_state != S_HRD) begin
            h_raddr = r_item.address[hmb_pkg::ADDR_W-1:0];
        end
    end

    assign s_raddr = (r_state == S_ARD) ? tri_v : r_item.address[hmb_pkg::ADDR_W-1:0];

    // write side of the sum memory: clear during the sweep, add afterwards
    always_comb begin
        s_we    = 1'b0;
        s_addr  = tri_v;
        s_wdata = '0;
        if (r_state == S_CLR) begin
            s_we   = 1'b1;
            s_addr = r_ptr;
        end else if (r_state == S_AWR) begin
            s_we      = 1'b1;
            s_wdata.x = r_sum_q.x + hmb_pkg::SUM_W'(r_tn.x);
            s_wdata.y = r_sum_q.y + hmb_pkg::SUM_W'(r_tn.y);
            s_wdata.z = r_sum_q.z + hmb_pkg::SUM_W'(r_tn.z);
        end
    end

    assign h_we = (r_state == S_LOAD) && (r_load_count < r_nv);
    assign n_load_count = h_we ? r_load_count + 1'b1 : r_load_count;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_height_mem[r_load_count[hmb_pkg::ADDR_W-1:0]] <= r_item.height;
            r_plate_mem[r_load_count[hmb_pkg::ADDR_W-1:0]]  <= r_item.plate_id;
        end
        r_height_q <= r_height_mem[h_raddr];
        r_plate_q  <= r_plate_mem[r_item.address[hmb_pkg::ADDR_W-1:0]];
    end

    // the read-modify-write never overlaps: each read waits for the prior write
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sum_mem[s_addr] <= s_wdata;
        end
        r_sum_q <= r_sum_mem[s_raddr];
    end

    // unit requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_item.address[hmb_pkg::ADDR_W-1:0];
        div_req.divisor  = r_side;
        if (r_item.kind == hmb_pkg::K_TRI) begin
            div_req.dividend = r_item.address[hmb_pkg::ADDR_W:1];
            div_req.divisor  = r_side - 1'b1;
        end
        if (r_state == S_DEC) begin
            if (r_item.kind == hmb_pkg::K_VERT) begin
                div_req.start = r_mesh_ready &&
                                (r_item.address < hmb_pkg::ADDR_W'(0) + r_nv);
            end else if (r_item.kind == hmb_pkg::K_TRI) begin
                div_req.start = r_mesh_ready &&
                                (hmb_pkg::TRI_W'(r_item.address) < r_ntri);
            end
        end
    end

    always_comb begin
        nrm_req.start = (r_state == S_TNRM) || (r_state == S_VNRM);
        nrm_req.vec   = r_sum_q;
        if (r_state == S_TNRM) begin
            nrm_req.vec.y = -hmb_pkg::SUM_W'(256);
            if (!r_tri) begin
                nrm_req.vec.x = hmb_pkg::SUM_W'(r_hq[2]) - hmb_pkg::SUM_W'(r_hq[1]);
                nrm_req.vec.z = hmb_pkg::SUM_W'(r_hq[0]) - hmb_pkg::SUM_W'(r_hq[1]);
            end else begin
                nrm_req.vec.x = hmb_pkg::SUM_W'(r_hq[3]) - hmb_pkg::SUM_W'(r_hq[0]);
                nrm_req.vec.z = hmb_pkg::SUM_W'(r_hq[3]) - hmb_pkg::SUM_W'(r_hq[2]);
            end
        end
    end

    // centring offset (side-1)*128 and the second triangle corner
    assign half = 16'({r_side - 1'b1, 7'b0});
    assign b_dn = r_base + hmb_pkg::ADDR_W'(r_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_side       <= hmb_pkg::SIDE_W'(hmb_pkg::MAX_SIDE);
            r_nv         <= hmb_pkg::CNT_W'(hmb_pkg::CELLS);
            r_ntri       <= hmb_pkg::TRI_W'(hmb_pkg::RESET_NTRI);
            r_load_count <= '0;
            r_mesh_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_side       <= cfg_side;
                r_nv         <= hmb_pkg::CNT_W'(cfg_sq);
                r_ntri       <= hmb_pkg::TRI_W'({cfg_q1sq, 1'b0});
                r_load_count <= '0;
                r_mesh_ready <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_word;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_res        <= '0;
                    r_res.status <= hmb_pkg::ST_BAD;
                    if (r_item.kind == hmb_pkg::K_LOAD) begin
                        r_state <= S_LOAD;
                    end else if (div_req.start) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_LOAD: begin
                    r_mesh_ready <= 1'b0;
                    if (n_load_count >= r_nv) begin
                        // grid complete: clear sums, then walk the quads
                        r_load_count <= '0;
                        r_ptr        <= '0;
                        r_state      <= S_CLR;
                    end else begin
                        r_load_count <= n_load_count;
                        r_res.status <= hmb_pkg::ST_LOADED;
                        r_state      <= S_PUSH;
                    end
                end
                S_CLR: begin
                    if (hmb_pkg::CNT_W'(r_ptr) == r_nv - 1'b1) begin
                        r_qi    <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_hstep <= '0;
                        r_state <= S_HRD;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_HRD: begin
                    if (r_hstep != 3'd0) begin
                        r_hq[r_hstep[1:0] - 2'd1] <= r_height_q;
                    end
                    if (r_hstep == 3'd4) begin
                        r_tri   <= 1'b0;
                        r_state <= S_TNRM;
                    end else begin
                        r_hstep <= r_hstep + 1'b1;
                    end
                end
                S_TNRM: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (nrm_rsp.done) begin
                        r_tn    <= nrm_rsp.nrm;
                        r_vk    <= 2'd0;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    if (r_vk != 2'd2) begin
                        r_vk    <= r_vk + 1'b1;
                        r_state <= S_ARD;
                    end else if (!r_tri) begin
                        r_tri   <= 1'b1;
                        r_state <= S_TNRM;
                    end else if (r_col == side_m2) begin
                        if (r_row == side_m2) begin
                            // last quad done
                            r_mesh_ready <= 1'b1;
                            r_res.status <= hmb_pkg::ST_BUILT;
                            r_state      <= S_PUSH;
                        end else begin
                            // skip the last column of the row
                            r_row   <= r_row + 1'b1;
                            r_col   <= '0;
                            r_qi    <= r_qi + hmb_pkg::ADDR_W'(2);
                            r_hstep <= '0;
                            r_state <= S_HRD;
                        end
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_qi    <= r_qi + 1'b1;
                        r_hstep <= '0;
                        r_state <= S_HRD;
                    end
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_state <= (r_item.kind == hmb_pkg::K_VERT) ? S_VRD : S_TIDX;
                    end
                end
                S_VRD: begin
                    r_state <= S_VNRM;
                end
                S_VNRM: begin
                    r_vh    <= r_height_q;
                    r_vp    <= r_plate_q;
                    r_state <= S_VWAIT;
                end
                S_VWAIT: begin
                    if (nrm_rsp.done) begin
                        r_res.status    <= hmb_pkg::ST_OK;
                        r_res.pos_x     <= 16'({div_rsp.rem, 8'h00}) - half;
                        r_res.pos_y     <= r_vh;
                        r_res.pos_z     <= half - 16'({div_rsp.quo, 8'h00});
                        r_res.normal_x  <= nrm_rsp.nrm.x;
                        r_res.normal_y  <= nrm_rsp.nrm.y;
                        r_res.normal_z  <= nrm_rsp.nrm.z;
                        r_res.plate_out <= r_vp;
                        r_state         <= S_PUSH;
                    end
                end
                S_TIDX: begin
                    r_base  <= hmb_pkg::ADDR_W'(div_rsp.quo * r_side)
                             + hmb_pkg::ADDR_W'(div_rsp.rem);
                    r_state <= S_TOUT;
                end
                S_TOUT: begin
                    r_res.status <= hmb_pkg::ST_OK;
                    if (!r_item.address[0]) begin
                        r_res.index_a <= 16'(r_base);
                        r_res.index_b <= 16'(b_dn);
                        r_res.index_c <= 16'(b_dn + 1'b1);
                    end else begin
                        r_res.index_a <= 16'(b_dn + 1'b1);
                        r_res.index_b <= 16'(r_base + 1'b1);
                        r_res.index_c <= 16'(r_base);
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // a finished mesh always leaves the load counter at zero
    a_ready_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mesh_ready |-> (r_load_count == '0))
        else $error("mesh ready with samples pending");

    // the load counter never reaches the vertex count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_load_count < r_nv))
        else $error("load counter out of range");

    // the clearing sweep stays inside the grid
    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (hmb_pkg::CNT_W'(r_ptr) < r_nv))
        else $error("clear pointer past the grid");

endmodule

// ----- sv/hmb_div.sv -----
// ----------------------------------------------------------------------------
// hmb_div: restoring divider, one quotient bit per cycle
// Splits a vertex index or quad number into row and column.
// ----------------------------------------------------------------------------
module hmb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmb_pkg::t_div_req i_req,
    output hmb_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [hmb_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [hmb_pkg::SIDE_W-1:0]          r_rem;
    logic [hmb_pkg::ADDR_W-1:0]          r_quo;
    logic [hmb_pkg::SIDE_W-1:0]          r_dvs;
    logic [hmb_pkg::SIDE_W:0]            trial;
    logic                                ge;

    assign trial = {r_rem, r_quo[hmb_pkg::ADDR_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? hmb_pkg::SIDE_W'(trial - {1'b0, r_dvs})
                            : hmb_pkg::SIDE_W'(trial);
                r_quo <= {r_quo[hmb_pkg::ADDR_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hmb_pkg::DIV_CNT_W'(hmb_pkg::ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- sv/hmb_norm.sv -----
// ----------------------------------------------------------------------------
// hmb_norm: vector normalizer to Q1.14
// Squares and sums the components, takes an integer square root two bits
// a cycle, then divides each component by the root one bit a cycle.
// ----------------------------------------------------------------------------
module hmb_norm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmb_pkg::t_nrm_req i_req,
    output hmb_pkg::t_nrm_rsp o_rsp
);

    localparam int ACC_W = 2 * hmb_pkg::SUM_W;
    localparam int RAD_W = ACC_W + 16;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int S_W = RAD_W / 2 + 1;
    localparam int NUM_W = hmb_pkg::SUM_W + 23;

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SQ   = 3'd1;
    localparam logic [2:0] N_CHK  = 3'd2;
    localparam logic [2:0] N_ROOT = 3'd3;
    localparam logic [2:0] N_DSET = 3'd4;
    localparam logic [2:0] N_DIV  = 3'd5;
    localparam logic [2:0] N_DFIN = 3'd6;

    logic [2:0]                    r_st;
    logic                          r_done;
    hmb_pkg::t_vec                 r_vec;
    hmb_pkg::t_nrm                 r_res;
    logic [1:0]                    r_k;
    logic [ACC_W-1:0]              r_acc;
    logic [RAD_W-1:0]              r_rad;
    logic [RAD_W-1:0]              r_root;
    logic [RAD_W-1:0]              r_bit;
    logic [4:0]                    r_cnt;
    logic [S_W-1:0]                r_rem;
    logic [15:0]                   r_low;
    logic [15:0]                   r_quo;
    logic                          r_neg;

    logic signed [hmb_pkg::SUM_W-1:0]   comp;
    logic signed [2*hmb_pkg::SUM_W-1:0] sq;
    logic [RAD_W-1:0]                   root_try;
    logic [S_W-1:0]                     s_val;
    logic [hmb_pkg::SUM_W-1:0]          mag;
    logic [NUM_W-1:0]                   num;
    logic [S_W:0]                       trial;
    logic                               ge;
    logic [15:0]                        qsat;
    logic signed [hmb_pkg::NRM_W-1:0]   qval;

    always_comb begin
        case (r_k)
            2'd0:    comp = r_vec.x;
            2'd1:    comp = r_vec.y;
            default: comp = r_vec.z;
        endcase
    end

    assign sq       = comp * comp;
    assign root_try = r_root + r_bit;
    assign s_val    = r_root[S_W-1:0];
    assign mag      = comp[hmb_pkg::SUM_W-1] ? hmb_pkg::SUM_W'(-comp)
                                             : hmb_pkg::SUM_W'(comp);
    assign num      = (NUM_W'(mag) << 22) + NUM_W'(s_val >> 1);
    assign trial    = {r_rem, r_low[15]};
    assign ge       = trial >= {1'b0, s_val};
    assign qsat     = (r_quo > 16'(hmb_pkg::UNIT)) ? 16'(hmb_pkg::UNIT) : r_quo;
    assign qval     = r_neg ? hmb_pkg::NRM_W'(-qsat) : hmb_pkg::NRM_W'(qsat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= N_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                N_IDLE: begin
                    if (i_req.start) begin
                        r_vec <= i_req.vec;
                        r_acc <= '0;
                        r_k   <= 2'd0;
                        r_st  <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_acc <= r_acc + ACC_W'(unsigned'(sq));
                    if (r_k == 2'd2) begin
                        r_k  <= 2'd0;
                        r_st <= N_CHK;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                N_CHK: begin
                    if (r_acc == '0) begin
                        // zero-length vector: report zero
                        r_res  <= '0;
                        r_done <= 1'b1;
                        r_st   <= N_IDLE;
                    end else begin
                        r_rad  <= {r_acc, 16'h0000};
                        r_root <= '0;
                        r_bit  <= RAD_W'(1) << (RAD_W - 2);
                        r_cnt  <= '0;
                        r_st   <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    if (r_rad >= root_try) begin
                        r_rad  <= r_rad - root_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                        r_st <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_rem <= S_W'(num[NUM_W-1:16]);
                    r_low <= num[15:0];
                    r_neg <= comp[hmb_pkg::SUM_W-1];
                    r_quo <= '0;
                    r_cnt <= '0;
                    r_st  <= N_DIV;
                end
                N_DIV: begin
                    r_rem <= ge ? S_W'(trial - {1'b0, s_val}) : S_W'(trial);
                    r_quo <= {r_quo[14:0], ge};
                    r_low <= {r_low[14:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd15) begin
                        r_st <= N_DFIN;
                    end
                end
                N_DFIN: begin
                    case (r_k)
                        2'd0:    r_res.x <= qval;
                        2'd1:    r_res.y <= qval;
                        default: r_res.z <= qval;
                    endcase
                    if (r_k == 2'd2) begin
                        r_done <= 1'b1;
                        r_st   <= N_IDLE;
                    end else begin
                        r_k  <= r_k + 1'b1;
                        r_st <= N_DSET;
                    end
                end
                default: r_st <= N_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.nrm  = r_res;

endmodule
